>>> hdl/assert_macros.svh
// assertion macros for the modules that check themselves
// no dependencies; assumes clk and rst in scope at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, off during reset
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition that must never hold
`define ASSERT_NEVER(lbl, expr) \
  `ASSERT_PROP(lbl, !(expr))

`endif

>>> hdl/ddo_pkg.sv
// shared types, constants and tables for the odometry block
// no dependencies
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int CFG_W  = 22;
  localparam int CIDX_W = 2;
  localparam logic [CIDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WBASE  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_STEPS  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_PERIOD = 2'd3;

  localparam logic [15:0] STEPS_RST  = 16'd20;
  localparam logic [15:0] PERIOD_RST = 16'd100;

  localparam int MD_AW = 64;
  localparam int MD_BW = 32;
  localparam int MD_PW = 96;
  localparam int DIVW  = 22;

  localparam logic [31:0] K2PI        = 32'd3373259426;
  localparam logic [31:0] KHEAD       = 32'd2734261102;
  localparam logic [33:0] KCORDIC     = 34'd652032874;
  localparam logic [31:0] SPEED_SCALE = 32'd1000;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_MAG_L  = 4'd0;
  localparam logic [OP_W-1:0] OP_DIST_L = 4'd1;
  localparam logic [OP_W-1:0] OP_MAG_R  = 4'd2;
  localparam logic [OP_W-1:0] OP_DIST_R = 4'd3;
  localparam logic [OP_W-1:0] OP_SPD_L  = 4'd4;
  localparam logic [OP_W-1:0] OP_SPD_R  = 4'd5;
  localparam logic [OP_W-1:0] OP_CORDIC = 4'd6;
  localparam logic [OP_W-1:0] OP_X      = 4'd7;
  localparam logic [OP_W-1:0] OP_Y      = 4'd8;
  localparam logic [OP_W-1:0] OP_HEAD   = 4'd9;

  typedef struct packed {
    logic            latch;
    logic            start;
    logic [OP_W-1:0] op;
    logic            commit;
  } cmd_t;

  typedef struct packed {
    logic step_done;
    logic out_busy;
  } sts_t;

  function automatic logic [31:0] atan_tab(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/ddo_muldiv.sv
// shared multiply then divide unit: floor(a*b/d), two 32x32 partial products
// then, if use_div is set, a restoring divider, one quotient bit per cycle; uses ddo_pkg
module ddo_muldiv (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           use_div,
  input  logic [ddo_pkg::MD_AW-1:0]      a,
  input  logic [ddo_pkg::MD_BW-1:0]      b,
  input  logic [ddo_pkg::DIVW-1:0]       d,
  output logic                           done,
  output logic [ddo_pkg::MD_PW-1:0]      q
);
  localparam int PW = ddo_pkg::MD_PW;
  localparam int BW = ddo_pkg::MD_BW;
  localparam int DW = ddo_pkg::DIVW;
  localparam int CW = $clog2(PW);
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MULHI = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;

  logic [1:0]      state;
  logic [PW-1:0]   prod;
  logic [BW-1:0]   a_hi;
  logic [BW-1:0]   b_r;
  logic [DW-1:0]   d_r;
  logic            div_r;
  logic [DW-1:0]   rem;
  logic [CW-1:0]   cnt;
  logic [BW-1:0]   mul_x;
  logic [BW-1:0]   mul_y;
  logic [2*BW-1:0] mult;
  logic [DW:0]     rem_sh;
  logic            ge;
  logic [DW:0]     rem_sub;

  assign mul_x   = (state == ST_IDLE) ? a[BW-1:0] : a_hi;
  assign mul_y   = (state == ST_IDLE) ? b : b_r;
  assign mult    = mul_x * mul_y;
  assign rem_sh  = {rem, prod[PW-1]};
  assign ge      = rem_sh >= {1'b0, d_r};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign q       = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            prod  <= {{(PW-2*BW){1'b0}}, mult};
            a_hi  <= a[2*BW-1:BW];
            b_r   <= b;
            d_r   <= d;
            div_r <= use_div;
            state <= ST_MULHI;
          end
        end
        ST_MULHI: begin
          prod <= prod + {mult, {BW{1'b0}}};
          if (div_r) begin
            rem   <= '0;
            cnt   <= '0;
            state <= ST_DIV;
          end else begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          rem  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
          prod <= {prod[PW-2:0], ge};
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(PW-1)) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/ddo_cordic.sv
// iterative cordic in rotation mode, one micro-rotation per cycle, q30
// uses ddo_pkg for the arctangent table and gain constant
module ddo_cordic #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);
  localparam int IW = $clog2(CORDIC_STEPS);

  logic               busy;
  logic               flip;
  logic [IW-1:0]      cnt;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic               flip_in;
  logic [31:0]        ang_in;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;

  assign flip_in = angle[31] ^ angle[30];
  assign ang_in  = flip_in ? {~angle[31], angle[30:0]} : angle;
  assign xs      = x >>> cnt;
  assign ys      = y >>> cnt;
  assign at      = $signed({2'b00, ddo_pkg::atan_tab(5'(cnt))});
  assign cos_o   = flip ? -x : x;
  assign sin_o   = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= $signed(ddo_pkg::KCORDIC);
        y    <= '0;
        z    <= $signed({{2{ang_in[31]}}, ang_in});
        flip <= flip_in;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!z[33]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        cnt <= cnt + 1'b1;
        if (cnt == IW'(CORDIC_STEPS-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> hdl/ddo_datapath.sv
// odometry datapath: configuration, pose state, operand selection and result
// registers; instantiates ddo_muldiv and ddo_cordic, uses ddo_pkg
module ddo_datapath #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ddo_pkg::cmd_t               cmd,
  output ddo_pkg::sts_t               sts,
  input  logic                        cfg_we,
  input  logic [ddo_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [ddo_pkg::CFG_W-1:0]   cfg_data,
  input  logic signed [31:0]          left_count,
  input  logic signed [31:0]          right_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          pos_x_um,
  output logic signed [31:0]          pos_y_um,
  output logic signed [15:0]          heading,
  output logic signed [31:0]          left_dist_um,
  output logic signed [31:0]          right_dist_um,
  output logic signed [31:0]          left_speed,
  output logic signed [31:0]          right_speed
);
  localparam int DW      = 32 + FRAC_BITS;
  localparam int SH_DIST = 29 - FRAC_BITS;
  localparam int PW      = ddo_pkg::MD_PW;
  localparam int AW      = ddo_pkg::MD_AW;
  localparam int QS      = 30;

  logic [19:0]          radius;
  logic [21:0]          wbase;
  logic [15:0]          steps;
  logic [15:0]          period;
  logic [31:0]          lc_r;
  logic [31:0]          rc_r;
  logic [31:0]          left_prev;
  logic [31:0]          right_prev;
  logic [47:0]          x_acc;
  logic [47:0]          y_acc;
  logic [31:0]          heading_acc;
  logic [AW-1:0]        tmp;
  logic signed [DW-1:0] dist_l;
  logic signed [DW-1:0] dist_r;
  logic [31:0]          spd_l;
  logic [31:0]          spd_r;
  logic signed [33:0]   cos_r;
  logic signed [33:0]   sin_r;
  logic [ddo_pkg::OP_W-1:0] op_r;

  logic [31:0]          dl_cnt;
  logic [31:0]          dr_cnt;
  logic [31:0]          dl_mag;
  logic [31:0]          dr_mag;
  logic signed [DW:0]   dsum;
  logic signed [DW-1:0] base;
  logic signed [DW:0]   ddiff;
  logic [DW-1:0]        base_mag;
  logic [DW-1:0]        dl_dmag;
  logic [DW-1:0]        dr_dmag;
  logic [DW:0]          dd_mag;
  logic signed [33:0]   cos_abs;
  logic signed [33:0]   sin_abs;
  logic [47:0]          inc48;
  logic [31:0]          inc32;
  logic signed [47:0]   xs;
  logic signed [47:0]   ys;

  logic                 md_start;
  logic                 md_div;
  logic [AW-1:0]        md_a;
  logic [31:0]          md_b;
  logic [ddo_pkg::DIVW-1:0] md_d;
  logic                 md_done;
  logic [PW-1:0]        md_q;
  logic                 co_start;
  logic                 co_done;
  logic signed [33:0]   co_cos;
  logic signed [33:0]   co_sin;

  function automatic logic [DW-1:0] clamp_dist(input logic [PW-1:0] qv, input logic neg);
    logic [PW-1:0] qs;
    logic [PW-1:0] cap;
    qs  = qv >> SH_DIST;
    cap = (PW'(1) << (31 + FRAC_BITS)) - (neg ? PW'(0) : PW'(1));
    if (qs > cap) qs = cap;
    return neg ? DW'(PW'(0) - qs) : DW'(qs);
  endfunction

  function automatic logic [31:0] clamp_speed(input logic [PW-1:0] qv, input logic neg);
    logic [PW-1:0] qs;
    logic [PW-1:0] cap;
    qs  = qv >> FRAC_BITS;
    cap = neg ? PW'(33'h080000000) : PW'(33'h07FFFFFFF);
    if (qs > cap) qs = cap;
    return neg ? 32'(PW'(0) - qs) : qs[31:0];
  endfunction

  assign dl_cnt   = lc_r - left_prev;
  assign dr_cnt   = rc_r - right_prev;
  assign dl_mag   = dl_cnt[31] ? 32'd0 - dl_cnt : dl_cnt;
  assign dr_mag   = dr_cnt[31] ? 32'd0 - dr_cnt : dr_cnt;
  assign dsum     = {dist_l[DW-1], dist_l} + {dist_r[DW-1], dist_r};
  assign base     = dsum[DW:1];
  assign ddiff    = {dist_r[DW-1], dist_r} - {dist_l[DW-1], dist_l};
  assign base_mag = base[DW-1] ? DW'(0) - base : base;
  assign dl_dmag  = dist_l[DW-1] ? DW'(0) - dist_l : dist_l;
  assign dr_dmag  = dist_r[DW-1] ? DW'(0) - dist_r : dist_r;
  assign dd_mag   = ddiff[DW] ? (DW+1)'(0) - ddiff : ddiff;
  assign cos_abs  = cos_r[33] ? -cos_r : cos_r;
  assign sin_abs  = sin_r[33] ? -sin_r : sin_r;
  assign inc48    = md_q[QS+47:QS];
  assign inc32    = md_q[FRAC_BITS+33:FRAC_BITS+2];
  assign xs       = $signed(x_acc) >>> FRAC_BITS;
  assign ys       = $signed(y_acc) >>> FRAC_BITS;

  always_comb begin
    md_start = 1'b0;
    md_div   = 1'b0;
    md_a     = '0;
    md_b     = '0;
    md_d     = ddo_pkg::DIVW'(1);
    co_start = 1'b0;
    if (cmd.start) begin
      case (cmd.op)
        ddo_pkg::OP_MAG_L: begin
          md_start = 1'b1;
          md_a     = AW'(dl_mag);
          md_b     = 32'(radius);
        end
        ddo_pkg::OP_MAG_R: begin
          md_start = 1'b1;
          md_a     = AW'(dr_mag);
          md_b     = 32'(radius);
        end
        ddo_pkg::OP_DIST_L, ddo_pkg::OP_DIST_R: begin
          md_start = 1'b1;
          md_div   = 1'b1;
          md_a     = tmp;
          md_b     = ddo_pkg::K2PI;
          md_d     = (steps == 16'd0) ? ddo_pkg::DIVW'(1) : ddo_pkg::DIVW'(steps);
        end
        ddo_pkg::OP_SPD_L, ddo_pkg::OP_SPD_R: begin
          md_start = 1'b1;
          md_div   = 1'b1;
          md_a     = (cmd.op == ddo_pkg::OP_SPD_L) ? AW'(dl_dmag) : AW'(dr_dmag);
          md_b     = ddo_pkg::SPEED_SCALE;
          md_d     = (period == 16'd0) ? ddo_pkg::DIVW'(1) : ddo_pkg::DIVW'(period);
        end
        ddo_pkg::OP_CORDIC: co_start = 1'b1;
        ddo_pkg::OP_X: begin
          md_start = 1'b1;
          md_a     = AW'(base_mag);
          md_b     = cos_abs[31:0];
        end
        ddo_pkg::OP_Y: begin
          md_start = 1'b1;
          md_a     = AW'(base_mag);
          md_b     = sin_abs[31:0];
        end
        ddo_pkg::OP_HEAD: begin
          md_start = 1'b1;
          md_div   = 1'b1;
          md_a     = AW'(dd_mag);
          md_b     = ddo_pkg::KHEAD;
          md_d     = (wbase == 22'd0) ? ddo_pkg::DIVW'(1) : wbase;
        end
        default: md_start = 1'b0;
      endcase
    end
  end

  ddo_muldiv u_muldiv (
    .clk     (clk),
    .rst     (rst),
    .start   (md_start),
    .use_div (md_div),
    .a       (md_a),
    .b       (md_b),
    .d       (md_d),
    .done    (md_done),
    .q       (md_q)
  );

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (co_start),
    .angle (heading_acc),
    .done  (co_done),
    .cos_o (co_cos),
    .sin_o (co_sin)
  );

  assign sts.step_done = md_done | co_done;
  assign sts.out_busy  = out_valid & out_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
      wbase  <= '0;
      steps  <= ddo_pkg::STEPS_RST;
      period <= ddo_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ddo_pkg::REG_RADIUS: radius <= cfg_data[19:0];
        ddo_pkg::REG_WBASE:  wbase  <= cfg_data;
        ddo_pkg::REG_STEPS:  steps  <= cfg_data[15:0];
        ddo_pkg::REG_PERIOD: period <= cfg_data[15:0];
        default:             radius <= radius;
      endcase
    end
  end

  // pose state, previous counts and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      left_prev   <= '0;
      right_prev  <= '0;
      x_acc       <= '0;
      y_acc       <= '0;
      heading_acc <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (md_done) begin
        case (op_r)
          ddo_pkg::OP_X: x_acc <= x_acc + ((base[DW-1] ^ cos_r[33]) ? 48'd0 - inc48 : inc48);
          ddo_pkg::OP_Y: y_acc <= y_acc + ((base[DW-1] ^ sin_r[33]) ? 48'd0 - inc48 : inc48);
          ddo_pkg::OP_HEAD: begin
            if (wbase != 22'd0)
              heading_acc <= heading_acc + (ddiff[DW] ? 32'd0 - inc32 : inc32);
          end
          default: x_acc <= x_acc;
        endcase
      end
      if (cmd.commit) begin
        left_prev  <= lc_r;
        right_prev <= rc_r;
        out_valid  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working and output registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lc_r <= left_count;
      rc_r <= right_count;
    end
    if (cmd.start) op_r <= cmd.op;
    if (co_done) begin
      cos_r <= co_cos;
      sin_r <= co_sin;
    end
    if (md_done) begin
      case (op_r)
        ddo_pkg::OP_MAG_L, ddo_pkg::OP_MAG_R: tmp <= md_q[AW-1:0];
        ddo_pkg::OP_DIST_L: dist_l <= clamp_dist(md_q, dl_cnt[31]);
        ddo_pkg::OP_DIST_R: dist_r <= clamp_dist(md_q, dr_cnt[31]);
        ddo_pkg::OP_SPD_L:  spd_l  <= clamp_speed(md_q, dist_l[DW-1]);
        ddo_pkg::OP_SPD_R:  spd_r  <= clamp_speed(md_q, dist_r[DW-1]);
        default:            tmp    <= tmp;
      endcase
    end
    if (cmd.commit) begin
      pos_x_um      <= xs[31:0];
      pos_y_um      <= ys[31:0];
      heading       <= heading_acc[31:16];
      left_dist_um  <= dist_l[DW-1:FRAC_BITS];
      right_dist_um <= dist_r[DW-1:FRAC_BITS];
      left_speed    <= spd_l;
      right_speed   <= spd_r;
    end
  end
endmodule

>>> hdl/ddo_ctrl.sv
// odometry controller: input transfer, sequencing of datapath steps, commit
// uses ddo_pkg command and status types
module ddo_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output ddo_pkg::cmd_t cmd,
  input  ddo_pkg::sts_t sts
);
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [ddo_pkg::OP_W-1:0] op;
  logic [ddo_pkg::OP_W-1:0] op_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd.latch  = 1'b0;
    cmd.start  = 1'b0;
    cmd.op     = op;
    cmd.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          op_next    = ddo_pkg::OP_MAG_L;
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.step_done) begin
          if (op == ddo_pkg::OP_HEAD) begin
            state_next = ST_COMMIT;
          end else begin
            op_next    = op + 1'b1;
            state_next = ST_ISSUE;
          end
        end
      end
      ST_COMMIT: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= ddo_pkg::OP_MAG_L;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end
endmodule

>>> hdl/differential_drive_odometry.sv
// differential drive odometry, top level; one sample in, one pose result out
// each input transfer is followed by five divider steps (serial divide of the
// 96-bit product), four multiply steps, a cordic step and a commit; the next
// input is taken only after that commit, which waits while the previous result
// is held stalled at the output
// rst (synchronous) clears pose, previous counts, output valid and configuration registers to their defaults
`include "assert_macros.svh"
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          left_count,
  input  logic signed [31:0]          right_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          pos_x_um,
  output logic signed [31:0]          pos_y_um,
  output logic signed [15:0]          heading,
  output logic signed [31:0]          left_dist_um,
  output logic signed [31:0]          right_dist_um,
  output logic signed [31:0]          left_speed,
  output logic signed [31:0]          right_speed,
  input  logic                        cfg_we,
  input  logic [ddo_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [ddo_pkg::CFG_W-1:0]   cfg_data
);
  ddo_pkg::cmd_t cmd;
  ddo_pkg::sts_t sts;

  ddo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  ddo_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .left_count    (left_count),
    .right_count   (right_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pos_x_um      (pos_x_um),
    .pos_y_um      (pos_y_um),
    .heading       (heading),
    .left_dist_um  (left_dist_um),
    .right_dist_um (right_dist_um),
    .left_speed    (left_speed),
    .right_speed   (right_speed)
  );

  `ASSERT_PROP(a_busy_after_transfer, (in_valid && !in_stall) |=> in_stall)
  `ASSERT_NEVER(a_commit_over_held, cmd.commit && sts.out_busy)
  `ASSERT_PROP(a_result_after_work, $rose(out_valid) |-> $past(in_stall))
endmodule
